// ----- sv/rtfp_pkg.sv -----
// Package for the radar target frame parser: frame byte codes, parse phases,
// record slot codes and the result type. No dependencies.
`default_nettype none

package rtfp_pkg;

    localparam logic [7:0]  HDR_BYTE      = 8'hA5;
    localparam logic [7:0]  CMD_BYTE      = 8'h82;
    localparam logic [7:0]  OP_BYTE       = 8'h00;
    localparam logic [15:0] MAX_LEN_RESET = 16'd802;
    localparam logic [15:0] CYCLE_BYTES   = 16'd2;

    localparam int REC_BYTES     = 8;
    localparam int SLOT_W        = $clog2(REC_BYTES);

    localparam logic [SLOT_W-1:0] SLOT_Y_LO   = SLOT_W'(2);
    localparam logic [SLOT_W-1:0] SLOT_Y_HI   = SLOT_W'(3);
    localparam logic [SLOT_W-1:0] SLOT_SNR_LO = SLOT_W'(6);
    localparam logic [SLOT_W-1:0] SLOT_SNR_HI = SLOT_W'(7);

    typedef enum logic [7:0] {
        PH_HDR1    = 8'b0000_0001,
        PH_HDR2    = 8'b0000_0010,
        PH_CMD     = 8'b0000_0100,
        PH_OP      = 8'b0000_1000,
        PH_LEN_LO  = 8'b0001_0000,
        PH_LEN_HI  = 8'b0010_0000,
        PH_PAYLOAD = 8'b0100_0000,
        PH_CHECK   = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic        valid;
        logic        status;
        logic        has_target;
        logic [15:0] min_y_cm;
    } result_t;

endpackage

`default_nettype wire

// ----- sv/radar_target_frame_parser.sv -----
// Top level of the radar target frame parser: byte input register, parser core,
// result register and the payload-limit configuration register.
// Depends on rtfp_pkg and rtfp_core.
// Data path: a byte request is registered in the input register, parsed by the core from
// there, and a frame's result is loaded into the result register. Throughput: one byte per
// cycle, held back only while a finished result waits. Reset clears all control state and sets the limit to 802.
`default_nettype none

module radar_target_frame_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             status,
    output logic             has_target,
    output logic [15:0]      min_y_cm
);
    import rtfp_pkg::*;

    logic        byte_valid_reg, byte_valid_next;
    logic [7:0]  byte_reg;
    logic [15:0] max_len_reg;
    result_t     res_reg;
    logic        out_valid_reg,  out_valid_next;
    result_t     core_res;
    logic        advance;
    logic        load;

    rtfp_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (byte_valid_reg && advance),
        .byte_in (byte_reg),
        .max_len (max_len_reg),
        .result  (core_res)
    );

    assign advance         = !(core_res.valid && out_valid_reg && !out_ready);
    assign in_ready        = !byte_valid_reg || advance;
    assign cfg_ready       = 1'b1;
    assign load            = byte_valid_reg && advance && core_res.valid;
    assign byte_valid_next = in_valid || (byte_valid_reg && !advance);
    assign out_valid_next  = load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            max_len_reg    <= MAX_LEN_RESET;
        end
        else
        begin
            if (in_ready)
            begin
                byte_valid_reg <= byte_valid_next;
            end
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                max_len_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
        if (load)
        begin
            res_reg <= core_res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = res_reg.status;
    assign has_target = res_reg.has_target;
    assign min_y_cm   = res_reg.min_y_cm;

`ifndef SYNTHESIS
    a_stall_only_on_full_out: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without a waiting result");
    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> byte_valid_reg)
        else $error("accepted byte lost from the input register");
    a_taken_result_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !load) |=> !out_valid)
        else $error("result presented twice");
    a_result_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (byte_valid_reg && core_res.valid))
        else $error("result loaded without a checksum byte");
`endif

endmodule

`default_nettype wire

// ----- sv/rtfp_core.sv -----
// Per-byte frame parsing state machine with checksum and minimum-Y tracking.
// Depends on rtfp_pkg for byte codes, phases and the result type.
`default_nettype none

module rtfp_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic [7:0]       byte_in,
    input  wire logic [15:0]      max_len,
    output rtfp_pkg::result_t     result
);
    import rtfp_pkg::*;

    phase_t            phase_reg,        phase_next;
    logic [7:0]        sum_reg,          sum_next;
    logic [15:0]       len_reg,          len_next;
    logic [15:0]       pos_reg,          pos_next;
    logic [7:0]        y_lo_reg,         y_lo_next;
    logic [15:0]       rec_y_reg,        rec_y_next;
    logic              rec_y_seen_reg,   rec_y_seen_next;
    logic [7:0]        snr_lo_reg,       snr_lo_next;
    logic [15:0]       min_y_reg,        min_y_next;
    logic              found_reg,        found_next;

    logic [15:0]       len_full;
    logic [SLOT_W-1:0] slot;
    logic [15:0]       snr;

    assign len_full = {byte_in, len_reg[7:0]};
    assign slot     = pos_reg[SLOT_W-1:0] - SLOT_W'(2);
    assign snr      = {byte_in, snr_lo_reg};

    always_comb
    begin
        phase_next      = phase_reg;
        sum_next        = sum_reg;
        len_next        = len_reg;
        pos_next        = pos_reg;
        y_lo_next       = y_lo_reg;
        rec_y_next      = rec_y_reg;
        rec_y_seen_next = rec_y_seen_reg;
        snr_lo_next     = snr_lo_reg;
        min_y_next      = min_y_reg;
        found_next      = found_reg;
        case (phase_reg)
            PH_HDR1:
            begin
                if (byte_in == HDR_BYTE)
                begin
                    sum_next   = byte_in;
                    phase_next = PH_HDR2;
                end
            end
            PH_HDR2:
            begin
                sum_next   = sum_reg + byte_in;
                phase_next = (byte_in == HDR_BYTE) ? PH_CMD : PH_HDR1;
            end
            PH_CMD:
            begin
                sum_next   = sum_reg + byte_in;
                phase_next = (byte_in == CMD_BYTE) ? PH_OP : PH_HDR1;
            end
            PH_OP:
            begin
                sum_next   = sum_reg + byte_in;
                phase_next = (byte_in == OP_BYTE) ? PH_LEN_LO : PH_HDR1;
            end
            PH_LEN_LO:
            begin
                len_next   = {8'd0, byte_in};
                sum_next   = sum_reg + byte_in;
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                len_next = len_full;
                sum_next = sum_reg + byte_in;
                if (len_full > max_len)
                begin
                    phase_next = PH_HDR1;
                end
                else
                begin
                    pos_next        = 16'd0;
                    min_y_next      = 16'd0;
                    found_next      = 1'b0;
                    rec_y_seen_next = 1'b0;
                    phase_next      = (len_full == 16'd0) ? PH_CHECK : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                sum_next = sum_reg + byte_in;
                if (pos_reg >= CYCLE_BYTES)
                begin
                    case (slot)
                        SLOT_Y_LO:   y_lo_next = byte_in;
                        SLOT_Y_HI:
                        begin
                            rec_y_next      = {byte_in, y_lo_reg};
                            rec_y_seen_next = 1'b1;
                        end
                        SLOT_SNR_LO: snr_lo_next = byte_in;
                        SLOT_SNR_HI:
                        begin
                            if (rec_y_seen_reg && snr != 16'd0)
                            begin
                                if (!found_reg || rec_y_reg < min_y_reg)
                                begin
                                    min_y_next = rec_y_reg;
                                end
                                found_next      = 1'b1;
                                rec_y_seen_next = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
                pos_next = pos_reg + 16'd1;
                if (pos_next >= len_reg)
                begin
                    phase_next = PH_CHECK;
                end
            end
            PH_CHECK:    phase_next = PH_HDR1;
            default:     phase_next = PH_HDR1;
        endcase
    end

    always_comb
    begin
        result.valid      = (phase_reg == PH_CHECK);
        result.status     = (sum_reg != byte_in);
        result.has_target = found_reg;
        result.min_y_cm   = min_y_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HDR1;
            sum_reg        <= 8'd0;
            len_reg        <= 16'd0;
            pos_reg        <= 16'd0;
            y_lo_reg       <= 8'd0;
            rec_y_reg      <= 16'd0;
            rec_y_seen_reg <= 1'b0;
            snr_lo_reg     <= 8'd0;
            min_y_reg      <= 16'd0;
            found_reg      <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            sum_reg        <= sum_next;
            len_reg        <= len_next;
            pos_reg        <= pos_next;
            y_lo_reg       <= y_lo_next;
            rec_y_reg      <= rec_y_next;
            rec_y_seen_reg <= rec_y_seen_next;
            snr_lo_reg     <= snr_lo_next;
            min_y_reg      <= min_y_next;
            found_reg      <= found_next;
        end
    end

endmodule

`default_nettype wire
